/* rtl/itoa_pkg.sv */
// Shared types and constants for the signed integer to decimal text converter.
package itoa_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 7;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int DIG_IDX_W  = 4;
	localparam int BIT_CNT_W  = 5;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;

	// One classified item: sign flag and unsigned magnitude.
	typedef struct packed {
		logic               minus;
		logic [VALUE_W-1:0] mag;
	} itoa_item_t;

	// Status of the queue as seen by the front and back ends.
	typedef struct packed {
		logic full;
		logic empty;
	} itoa_q_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_SIGN,
		ST_DIGITS
	} itoa_state_t;

endpackage

/* rtl/signed_int_to_decimal_ascii_top.sv */
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
//  Channel    Handshake                 Payload          Direction
//  ---------  ------------------------  ---------------  ---------
//  value      value_valid/value_ready   value[31:0]      in
//  character  char_valid/char_ready     character, last  out
//
// Each item goes through the back end in order: a load, 32 shift-and-adjust
// steps of the BCD converter and a scan for the leading digit, then one
// character per cycle unless stalled: a minus sign if negative plus one to
// ten digits.
// The front end and the queue keep taking items while the back end works.
// Reset clears the handshake, queue and sequencer state; data is not reset.
// A character-side stall holds the current character, not the BCD steps.
module signed_int_to_decimal_ascii_top import itoa_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               value_valid,
	output logic               value_ready,
	input  logic [VALUE_W-1:0] value,
	output logic               char_valid,
	input  logic               char_ready,
	output logic [CHAR_W-1:0]  character,
	output logic               last
);

	// Items classified by the front end wait here until the back end is free.
	itoa_q_stat_t q_stat;
	itoa_item_t   push_item;
	itoa_item_t   pop_item;
	logic         push;
	logic         pop;

	// The front end registers the sign and the magnitude of each item.
	itoa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.value       (value),
		.q_stat      (q_stat),
		.push        (push),
		.push_item   (push_item)
	);

	itoa_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	// The back end converts one item at a time and drives the output register.
	itoa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.pop_item   (pop_item),
		.pop        (pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.character  (character),
		.last       (last)
	);

endmodule

/* rtl/itoa_front.sv */
// Front end: accepts an integer item, splits off its sign and forms the magnitude.
module itoa_front import itoa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               value_valid,
	output logic               value_ready,
	input  logic [VALUE_W-1:0] value,
	input  itoa_q_stat_t       q_stat,
	output logic               push,
	output itoa_item_t         push_item
);

	logic       valid_s1;
	itoa_item_t item_s1;
	logic       take;

	assign push        = valid_s1 && !q_stat.full;
	assign value_ready = !valid_s1 || !q_stat.full;
	assign take        = value_valid && value_ready;
	assign push_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Two's complement negation; the most negative value maps onto its own
	// bit pattern, which read unsigned is the correct magnitude.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.minus <= value[VALUE_W-1];
			item_s1.mag   <= value[VALUE_W-1] ? (~value + {{(VALUE_W-1){1'b0}}, 1'b1})
			                                  : value;
		end
	end

endmodule

/* rtl/itoa_fifo.sv */
// Small queue of classified items between the front and back ends.
module itoa_fifo import itoa_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  itoa_item_t   push_item,
	input  logic         pop,
	output itoa_item_t   pop_item,
	output itoa_q_stat_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	itoa_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign q_stat.full  = (count_q == FULL_CNT);
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign pop_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/itoa_back.sv */
// Back end: bit-serial binary to BCD conversion, then one character per cycle unless stalled.
module itoa_back import itoa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  itoa_q_stat_t      q_stat,
	input  itoa_item_t        pop_item,
	output logic              pop,
	output logic              char_valid,
	input  logic              char_ready,
	output logic [CHAR_W-1:0] character,
	output logic              last
);

	itoa_state_t          state_q;
	itoa_state_t          state_d;
	logic [VALUE_W-1:0]   sh_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     bcd_adj;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic                 minus_q;
	logic [DIG_IDX_W-1:0] dig_q;
	logic [DIG_IDX_W-1:0] top_dig;
	logic [3:0]           cur_nib;
	logic                 valid_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;
	logic                 can_load;
	logic                 load_sign;
	logic                 load_digit;

	assign can_load   = !valid_q || char_ready;
	assign char_valid = valid_q;
	assign character  = char_q;
	assign last       = last_q;
	assign cur_nib    = bcd_q[{dig_q, 2'b00} +: 4];

	// Add three to every digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                              : bcd_q[4*i +: 4];
		end
	end

	// Highest nonzero digit; zero when the whole number is zero.
	always_comb begin
		top_dig = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				top_dig = DIG_IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (cnt_q == '1) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				state_d = minus_q ? ST_SIGN : ST_DIGITS;
			end
			ST_SIGN: begin
				if (can_load) begin
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (can_load && dig_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		load_sign  = 1'b0;
		load_digit = 1'b0;
		case (state_q)
			ST_IDLE:   pop        = !q_stat.empty;
			ST_SIGN:   load_sign  = can_load;
			ST_DIGITS: load_digit = can_load;
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_sign || load_digit) begin
				valid_q <= 1'b1;
			end else if (char_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q    <= pop_item.mag;
			minus_q <= pop_item.minus;
			bcd_q   <= '0;
			cnt_q   <= '0;
		end
		if (state_q == ST_CONV) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], sh_q[VALUE_W-1]};
			sh_q  <= {sh_q[VALUE_W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == ST_SCAN) begin
			dig_q <= top_dig;
		end
		if (load_digit && dig_q != '0) begin
			dig_q <= dig_q - 1'b1;
		end
		if (load_sign) begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
		end else if (load_digit) begin
			char_q <= CH_ZERO + {3'b000, cur_nib};
			last_q <= (dig_q == '0);
		end
	end

endmodule
